@@ design/cfd_pkg.sv @@
package cfd_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int TOTAL_W     = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] SYNC_BYTE   = 8'hAF;
    localparam logic [7:0] TAIL_FIRST  = 8'h19;
    localparam logic [7:0] TAIL_SECOND = 8'h3F;
    localparam logic [15:0] FRAME_OVERHEAD = 16'd8;

    // Event codes carried on event_res.
    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_DATA = 3'd1;
    localparam logic [2:0] EV_OK   = 3'd2;
    localparam logic [2:0] EV_SUM  = 3'd3;
    localparam logic [2:0] EV_TAIL = 3'd4;
    localparam logic [2:0] EV_LEN  = 3'd5;

    // Parser phases.
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_SYNC1   = 4'd1;
    localparam logic [3:0] PH_SYNC2   = 4'd2;
    localparam logic [3:0] PH_LEN1    = 4'd3;
    localparam logic [3:0] PH_LEN2    = 4'd4;
    localparam logic [3:0] PH_PAYLOAD = 4'd5;
    localparam logic [3:0] PH_CHECK   = 4'd6;
    localparam logic [3:0] PH_TAIL1   = 4'd7;
    localparam logic [3:0] PH_TAIL2   = 4'd8;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] data;
        logic [7:0] idx;
        logic [7:0] ftype;
        logic [8:0] plen;
    } res_t;

    function automatic logic [7:0] idx8(input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W+7:0] w;
        w = {8'd0, v};
        return w[7:0];
    endfunction

    function automatic logic [8:0] len9(input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W+8:0] w;
        w = {9'd0, v};
        return w[8:0];
    endfunction

endpackage

@@ design/cfd_parser.sv @@
module cfd_parser
    import cfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    output res_t       res
);

    logic [3:0]         phase_reg, phase_next;
    logic [7:0]         len_lo_reg, len_lo_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] count_reg, count_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         type_reg, type_next;

    logic [15:0]        len_word;
    logic [15:0]        len_excess;
    logic               len_ok;
    logic [TOTAL_W-1:0] count_inc;
    logic [7:0]         sum_add;

    assign len_word   = {byte_in, len_lo_reg};
    assign len_excess = len_word - FRAME_OVERHEAD;
    assign len_ok     = (len_word >= FRAME_OVERHEAD) && (len_excess <= 16'(MAX_PAYLOAD));
    assign count_inc  = count_reg + TOTAL_W'(1);
    assign sum_add    = sum_reg + byte_in;

    always_comb
    begin
        phase_next  = phase_reg;
        len_lo_next = len_lo_reg;
        total_next  = total_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        type_next   = type_reg;
        res         = '0;

        unique case (phase_reg)
            PH_SYNC1:
            begin
                phase_next = (byte_in == SYNC_BYTE) ? PH_SYNC2 : PH_IDLE;
            end
            PH_SYNC2:
            begin
                // The byte after two sync bytes is always the low length byte.
                len_lo_next = byte_in;
                sum_next    = byte_in;
                count_next  = '0;
                total_next  = '0;
                type_next   = '0;
                phase_next  = PH_LEN1;
            end
            PH_LEN1:
            begin
                sum_next = sum_add;
                if (!len_ok)
                begin
                    phase_next = PH_IDLE;
                    res.ev     = EV_LEN;
                end
                else
                begin
                    total_next = len_excess[TOTAL_W-1:0];
                    phase_next = PH_LEN2;
                end
            end
            PH_LEN2:
            begin
                type_next  = byte_in;
                sum_next   = sum_add;
                count_next = '0;
                phase_next = (total_reg == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_next   = sum_add;
                count_next = count_inc;
                if (count_inc >= total_reg)
                begin
                    phase_next = PH_CHECK;
                end
                res.ev    = EV_DATA;
                res.data  = byte_in;
                res.idx   = idx8(count_reg);
                res.ftype = type_reg;
                res.plen  = len9(total_reg);
            end
            PH_CHECK:
            begin
                if (byte_in != sum_reg)
                begin
                    phase_next = PH_IDLE;
                    res.ev     = EV_SUM;
                    res.ftype  = type_reg;
                    res.plen   = len9(total_reg);
                end
                else
                begin
                    phase_next = PH_TAIL1;
                end
            end
            PH_TAIL1:
            begin
                if (byte_in != TAIL_FIRST)
                begin
                    phase_next = PH_IDLE;
                    res.ev     = EV_TAIL;
                    res.ftype  = type_reg;
                    res.plen   = len9(total_reg);
                end
                else
                begin
                    phase_next = PH_TAIL2;
                end
            end
            PH_TAIL2:
            begin
                phase_next = PH_IDLE;
                res.ev     = (byte_in == TAIL_SECOND) ? EV_OK : EV_TAIL;
                res.ftype  = type_reg;
                res.plen   = len9(total_reg);
            end
            default:
            begin
                // Idle and any unused code hunt for the first sync byte.
                phase_next = (byte_in == SYNC_BYTE) ? PH_SYNC1 : PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_lo_reg <= '0;
            total_reg  <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            type_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            len_lo_reg <= len_lo_next;
            total_reg  <= total_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            type_reg   <= type_next;
        end
    end

endmodule

@@ design/checksummed_frame_deframer.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// rx       | rx_valid / rx_ready  | rx_byte
// res      | res_valid / res_ready| event_res, data_byte, byte_index, frame_type,
//          |                      | payload_length
//
// Every received beat produces exactly one result beat, event none included.
// One byte per cycle sustained while the receiver takes results; a byte passes
// through the input register, then the parser step into the result register.
// rst_n clears the parser to idle and empties both registers.
// A stalled result register holds the byte in the input register; rx_ready
// stays high as long as either register can move.
module checksummed_frame_deframer
    import cfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [2:0] event_res,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic [7:0] frame_type,
    output logic [8:0] payload_length
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    res_t       out_reg;
    res_t       step_res;
    logic       advance;
    logic       rx_take;

    assign advance  = in_valid_reg && (!out_valid_reg || res_ready);
    assign rx_ready = !in_valid_reg || !out_valid_reg || res_ready;
    assign rx_take  = rx_valid && rx_ready;

    cfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .res     (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    assign res_valid      = out_valid_reg;
    assign event_res      = out_reg.ev;
    assign data_byte      = out_reg.data;
    assign byte_index     = out_reg.idx;
    assign frame_type     = out_reg.ftype;
    assign payload_length = out_reg.plen;

endmodule

@@ design/cfd_checker.sv @@
module cfd_checker
    import cfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] event_res,
    input logic [7:0] data_byte,
    input logic [7:0] byte_index,
    input logic [7:0] frame_type,
    input logic [8:0] payload_length
);

    // A stalled result beat holds its whole payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(data_byte)
            && $stable(byte_index) && $stable(frame_type) && $stable(payload_length))
        else $error("result beat changed while stalled");

    // A receiver that takes results never stalls the input.
    a_rx_open: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> rx_ready)
        else $error("input stalled while the receiver is ready");

    a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> event_res <= EV_LEN)
        else $error("event code out of range");

    // Only payload beats carry a data byte and an index.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res != EV_DATA |-> data_byte == 8'd0 && byte_index == 8'd0)
        else $error("data or index set outside a payload beat");

    // No frame information outside a frame or on a rejected length.
    a_info_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (event_res == EV_NONE || event_res == EV_LEN)
            |-> frame_type == 8'd0 && payload_length == 9'd0)
        else $error("frame information set without a frame");

endmodule

bind checksummed_frame_deframer cfd_checker u_cfd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_ready       (rx_ready),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .event_res      (event_res),
    .data_byte      (data_byte),
    .byte_index     (byte_index),
    .frame_type     (frame_type),
    .payload_length (payload_length)
);
